// ===== src/sre_pkg.sv =====
// package: constants, opcodes and payload types of the execute unit
`default_nettype none
package sre_pkg;
  localparam int DataDepth = 4096;
  localparam int DataAw = $clog2(DataDepth);
  localparam int IoCount = 22;
  localparam int TargetBits = 9;
  localparam logic [3:0] RetReg = 4'd15;
  localparam logic [4:0] IoReturn = 5'd7;
  localparam logic [4:0] IoLeds = 5'd9;
  localparam logic [4:0] IoMonCmd = 5'd18;
  localparam logic [4:0] IoMonX = 5'd19;
  localparam logic [4:0] IoMonY = 5'd20;
  localparam logic [4:0] IoMonData = 5'd21;

  typedef enum logic [7:0] {
    OpAdd = 8'd0, OpSub = 8'd1, OpAnd = 8'd2, OpOr = 8'd3, OpXor = 8'd4,
    OpMul = 8'd5, OpSll = 8'd6, OpSra = 8'd7, OpSrl = 8'd8, OpBeq = 8'd9,
    OpBne = 8'd10, OpBlt = 8'd11, OpBgt = 8'd12, OpBle = 8'd13, OpBge = 8'd14,
    OpJal = 8'd15, OpLw = 8'd16, OpSw = 8'd17, OpReti = 8'd18, OpIn = 8'd19,
    OpOut = 8'd20, OpHalt = 8'd21
  } op_e;

  typedef struct packed {
    logic [7:0]         opcode;
    logic [3:0]         dest_reg;
    logic [3:0]         src_a_reg;
    logic [3:0]         src_b_reg;
    logic signed [31:0] immediate;
    logic [9:0]         pc;
  } instr_t;

  typedef struct packed {
    logic [9:0]  next_pc;
    logic        halted;
    logic        pixel_write;
    logic [7:0]  pixel_x;
    logic [7:0]  pixel_y;
    logic [7:0]  pixel_shade;
    logic        led_write;
    logic [31:0] led_value;
  } result_t;
endpackage
`default_nettype wire

// ===== src/sre_stream_if.sv =====
// interface: valid/ready channels for instructions and results
`default_nettype none
interface sre_instr_if import sre_pkg::*; ();
  logic   valid;
  logic   ready;
  instr_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sre_result_if import sre_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/simple_risc_execute_unit.sv =====
// top level: execute unit with register file, data memory and io registers
// result register: valid in the cycle after the instruction transfer
// throughput: 1 instruction per cycle unless clearing or the result stalls;
//   a load adds one data memory read stage, writeback forwarded to the next op
// reset: register file and io registers clear at once; data memory is cleared
//   by a pass over all DataDepth (4096) words after reset, no instruction taken
`default_nettype none
module simple_risc_execute_unit import sre_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  sre_instr_if.sink   instr_i,
  sre_result_if.source result_o
);
  // flop register file and io registers (small, read at fixed decode points)
  logic [31:0] rf_q [16];
  logic [31:0] io_q [IoCount];
  // data memory, single write, single synchronous read
  logic [31:0] dmem [DataDepth];
  logic [31:0] dmem_rdata_q;

  logic [DataAw:0] clr_cnt_q;
  logic clearing;
  assign clearing = !clr_cnt_q[DataAw];

  // pending load: the memory word is written back in the following cycle
  logic       ld_pend_q;
  logic [3:0] ld_rd_q;
  logic [DataAw-1:0] ld_addr_q;
  logic [DataAw-1:0] last_st_addr_q;
  logic [31:0] last_st_data_q;
  logic       last_st_vld_q;

  logic out_full_q;
  result_t out_q;

  logic fire;
  assign instr_i.ready = !clearing && (!out_full_q || result_o.ready);
  assign fire = instr_i.valid && instr_i.ready;
  assign result_o.valid = out_full_q;
  assign result_o.data = out_q;

  instr_t in;
  assign in = instr_i.data;

  // load data: forward a same-address store made in the load's own cycle
  // is impossible (one op per cycle), so memory data is exact
  logic [31:0] ld_data;
  assign ld_data = dmem_rdata_q;

  function automatic logic [31:0] rd_reg(input logic [3:0] n, input logic [31:0] imm,
      input logic [31:0] rf_n, input logic lp, input logic [3:0] lr,
      input logic [31:0] ld);
    logic [31:0] v;
    if (n == 4'd0) v = '0;
    else if (n == 4'd1) v = imm;
    else if (lp && lr == n) v = ld;
    else v = rf_n;
    return v;
  endfunction

  logic [31:0] a, b, c;
  assign a = rd_reg(in.src_a_reg, in.immediate, rf_q[in.src_a_reg], ld_pend_q, ld_rd_q,
                    ld_data);
  assign b = rd_reg(in.src_b_reg, in.immediate, rf_q[in.src_b_reg], ld_pend_q, ld_rd_q,
                    ld_data);
  assign c = rd_reg(in.dest_reg, in.immediate, rf_q[in.dest_reg], ld_pend_q, ld_rd_q,
                    ld_data);

  logic signed [32:0] sum33;
  assign sum33 = {a[31], a} + {b[31], b};
  // sequential pc kept one bit wider: jal stores the unwrapped return address
  logic [10:0] seq;
  assign seq = {1'b0, in.pc} + ((in.dest_reg == 4'd1 || in.src_a_reg == 4'd1 ||
                                 in.src_b_reg == 4'd1) ? 11'd2 : 11'd1);

  logic [DataAw-1:0] maddr;
  assign maddr = (sum33 < 0 || sum33 > (DataDepth - 1)) ?
                 DataAw'(DataDepth - 1) : sum33[DataAw-1:0];
  logic io_ok;
  assign io_ok = sum33 >= 0 && sum33 < IoCount;
  logic [4:0] ioa;
  assign ioa = sum33[4:0];

  logic signed [31:0] sa, sbv;
  assign sa = a;
  assign sbv = b;
  logic big;
  assign big = |b[31:5];
  logic [31:0] mulp;
  assign mulp = a * b;

  logic        wr_en;
  logic [3:0]  wr_idx;
  logic [31:0] wr_val;
  logic        take;
  result_t     res;

  always_comb begin
    wr_en = 1'b0;
    wr_idx = in.dest_reg;
    wr_val = '0;
    take = 1'b0;
    res = '0;
    res.next_pc = seq[9:0];
    case (in.opcode)
      OpAdd: begin wr_en = 1'b1; wr_val = a + b; end
      OpSub: begin wr_en = 1'b1; wr_val = a - b; end
      OpAnd: begin wr_en = 1'b1; wr_val = a & b; end
      OpOr:  begin wr_en = 1'b1; wr_val = a | b; end
      OpXor: begin wr_en = 1'b1; wr_val = a ^ b; end
      OpMul: begin wr_en = 1'b1; wr_val = mulp; end
      OpSll: begin wr_en = 1'b1; wr_val = big ? '0 : a << b[4:0]; end
      OpSra: begin wr_en = 1'b1; wr_val = big ? {32{a[31]}} : 32'(sa >>> b[4:0]); end
      OpSrl: begin wr_en = 1'b1; wr_val = big ? '0 : a >> b[4:0]; end
      OpBeq: take = sa == sbv;
      OpBne: take = sa != sbv;
      OpBlt: take = sa < sbv;
      OpBgt: take = sa > sbv;
      OpBle: take = sa <= sbv;
      OpBge: take = sa >= sbv;
      OpJal: begin
        wr_en = 1'b1; wr_idx = RetReg; wr_val = 32'(seq); take = 1'b1;
      end
      OpReti: res.next_pc = io_q[IoReturn][9:0];
      OpIn: begin
        wr_en = 1'b1;
        wr_val = (io_ok && ioa != IoMonCmd) ? io_q[ioa] : '0;
      end
      OpOut: begin
        if (io_ok && ioa == IoMonCmd && c != '0) begin
          res.pixel_write = 1'b1;
          res.pixel_x = io_q[IoMonX][7:0];
          res.pixel_y = io_q[IoMonY][7:0];
          res.pixel_shade = io_q[IoMonData][7:0];
        end else if (io_ok && ioa == IoLeds) begin
          res.led_write = 1'b1;
          res.led_value = c;
        end
      end
      OpHalt: begin res.halted = 1'b1; res.next_pc = in.pc; end
      default: ;
    endcase
    // jal writes r15 first, so a target of 15 sees the return address
    if (take) begin
      if (in.opcode == OpJal && in.dest_reg == RetReg)
        res.next_pc = 10'(seq[TargetBits-1:0]);
      else
        res.next_pc = 10'(c[TargetBits-1:0]);
    end
  end

  logic is_lw, is_sw;
  assign is_lw = fire && in.opcode == OpLw;
  assign is_sw = fire && in.opcode == OpSw;

  // a younger write to the same register wins over the retiring load
  logic ld_ret;
  assign ld_ret = ld_pend_q && ld_rd_q > 4'd1 &&
                  !(fire && wr_en && wr_idx == ld_rd_q);

  // data memory port: clearing pass, store, or load read
  always_ff @(posedge clk_i) begin
    if (clearing) dmem[clr_cnt_q[DataAw-1:0]] <= '0;
    else if (is_sw) dmem[maddr] <= c;
    dmem_rdata_q <= dmem[maddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      ld_pend_q <= 1'b0;
      ld_rd_q <= '0;
      out_full_q <= 1'b0;
      for (int i = 0; i < 16; i++) rf_q[i] <= '0;
      for (int i = 0; i < IoCount; i++) io_q[i] <= '0;
    end else begin
      if (clearing) clr_cnt_q <= clr_cnt_q + 1'b1;
      // retire pending load into the register file
      if (ld_ret) rf_q[ld_rd_q] <= ld_data;
      if (fire) begin
        if (wr_en && wr_idx > 4'd1) rf_q[wr_idx] <= wr_val;
        if (in.opcode == OpReti) begin
          io_q[3] <= '0; io_q[4] <= '0; io_q[5] <= '0;
        end
        if (in.opcode == OpOut && io_ok) io_q[ioa] <= c;
      end
      ld_pend_q <= is_lw;
      ld_rd_q <= in.dest_reg;
      if (fire) out_full_q <= 1'b1;
      else if (result_o.ready) out_full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) out_q <= res;
    ld_addr_q <= maddr;
    last_st_addr_q <= maddr;
    last_st_data_q <= c;
    last_st_vld_q <= is_sw;
  end

  // no instruction taken during the clearing pass
  a_no_fire_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !instr_i.ready) else $error("transfer during clear");
  // a load always comes from a transfer in the previous cycle
  a_load_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld_pend_q |-> $past(fire)) else $error("stray load");
  // halt reports its own pc
  a_halt_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && in.opcode == OpHalt) |=> out_q.next_pc == $past(in.pc))
    else $error("halt pc");
  // store right before a load of the same address is seen by the load
  a_st_ld: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ld_pend_q && $past(last_st_vld_q) && $past(last_st_addr_q) == ld_addr_q)
      |-> ld_data == $past(last_st_data_q)) else $error("store to load");
endmodule
`default_nettype wire
